// ===== design/nrbh_pkg.sv =====
// ----------------------------------------------------------------------------
// nrbh_pkg: shared types and constants for the nearest ray box hit block
// Payload structs, register indexes, controller states and command struct.
// ----------------------------------------------------------------------------
package nrbh_pkg;

    localparam int CW  = 24;
    localparam int IDW = 16;
    localparam int TW  = 32;
    // Numerator width: CW+1 bits of (offset + extent), shifted by 16.
    localparam int NW  = CW + 1 + 16;
    localparam int QW  = NW;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_DIR_X    = 3'd2,
        REG_DIR_Y    = 3'd3,
        REG_RANGE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0]  box_x;
        logic signed [CW-1:0]  box_y;
        logic        [CW-2:0]  box_w;
        logic        [CW-2:0]  box_h;
        logic        [IDW-1:0] box_id;
        logic                  is_own;
        logic                  is_target;
        logic                  is_wall;
        logic                  last_box;
    } box_item_t;

    typedef struct packed {
        logic                  hit_found;
        logic        [IDW-1:0] hit_id;
        logic                  hit_wall;
        logic signed [TW-1:0]  hit_time;
        logic signed [CW-1:0]  contact_x;
        logic signed [CW-1:0]  contact_y;
    } hit_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_DIST,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EVAL,
        ST_MUL,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       filt;
        logic       dist_chk;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       eval;
        logic       mul;
        logic       update;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic div_zero;
        logic miss;
        logic last;
    } status_t;

endpackage

// ===== design/nrbh_div.sv =====
// ----------------------------------------------------------------------------
// nrbh_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module nrbh_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [nrbh_pkg::NW-1:0]  num,
    input  logic signed [nrbh_pkg::CW-1:0]  den,
    output logic                            done,
    output logic signed [nrbh_pkg::QW-1:0]  quo
);
    localparam int CNTW = $clog2(nrbh_pkg::NW + 1);

    logic [nrbh_pkg::NW-1:0] q_reg, q_next;
    logic [nrbh_pkg::CW:0]   r_reg, r_next;
    logic [nrbh_pkg::CW-1:0] d_reg, d_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [nrbh_pkg::CW+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = num[nrbh_pkg::NW-1] ? nrbh_pkg::NW'(-num) : num;
            d_next    = den[nrbh_pkg::CW-1] ? nrbh_pkg::CW'(-den) : den;
            r_next    = '0;
            neg_next  = num[nrbh_pkg::NW-1] ^ den[nrbh_pkg::CW-1];
            cnt_next  = CNTW'(nrbh_pkg::NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift one numerator bit into the remainder, subtract if it fits.
            trial = {r_reg, q_reg[nrbh_pkg::NW-1]} - {2'b00, d_reg};
            if (!trial[nrbh_pkg::CW+1])
            begin
                r_next = trial[nrbh_pkg::CW:0];
                q_next = {q_reg[nrbh_pkg::NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[nrbh_pkg::CW-1:0], q_reg[nrbh_pkg::NW-1]};
                q_next = {q_reg[nrbh_pkg::NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? nrbh_pkg::QW'(-q_reg) : q_reg;
endmodule

// ===== design/nrbh_datapath.sv =====
// ----------------------------------------------------------------------------
// nrbh_datapath: registers and arithmetic for one box test
// Filter, squared distance, four slab times, hit rule, contact point, best hit.
// ----------------------------------------------------------------------------
module nrbh_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nrbh_pkg::cmd_t              cmd,
    output nrbh_pkg::status_t           status,
    input  nrbh_pkg::box_item_t         box,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_idx,
    input  logic [nrbh_pkg::CW-1:0]     cfg_data,
    output nrbh_pkg::hit_item_t         result
);
    localparam int CW = nrbh_pkg::CW;
    localparam int NW = nrbh_pkg::NW;
    localparam int EW = 66;   // slab time, room for infinity marks
    localparam int XW = nrbh_pkg::TW + CW - 15;   // contact point before clamping
    localparam logic signed [EW-1:0] T_INF = EW'(64'sh4000_0000_0000_0000);
    localparam logic signed [EW-1:0] T_MAX = EW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [EW-1:0] T_MIN = -EW'(64'sh0000_0000_8000_0000);

    logic signed [CW-1:0] ox_reg, oy_reg, dx_reg, dy_reg;
    logic        [CW-2:0] rng_reg;
    nrbh_pkg::box_item_t  box_reg;
    logic signed [CW+1:0] ddx_reg, ddy_reg;
    logic                 skip_reg, miss_reg;
    logic signed [EW-1:0] tm_reg [4];
    logic                 zd_reg [4];
    logic signed [nrbh_pkg::TW-1:0] ts_reg;
    logic signed [nrbh_pkg::TW+CW-1:0] px_reg, py_reg;
    logic                 best_v_reg, best_w_reg;
    logic [nrbh_pkg::IDW-1:0] best_id_reg;
    logic signed [nrbh_pkg::TW-1:0] best_t_reg;
    logic signed [CW-1:0] best_cx_reg, best_cy_reg;
    nrbh_pkg::hit_item_t  res_reg;

    logic signed [CW+1:0] ddx, ddy, num_off, absx, absy;
    logic signed [CW-1:0] den;
    logic signed [NW-1:0] num;
    logic                 div_done;
    logic signed [nrbh_pkg::QW-1:0] quo;
    logic signed [EW-1:0] nx, fx, ny, fy, tn, tf, ts_w;
    logic signed [XW-1:0] cx, cy;
    logic signed [CW-1:0] cxs, cys;
    logic [2*CW+3:0]      dist2, rng2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            dx_reg  <= CW'(256);
            dy_reg  <= '0;
            rng_reg <= '1;
            best_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    nrbh_pkg::REG_ORIGIN_X: ox_reg  <= cfg_data;
                    nrbh_pkg::REG_ORIGIN_Y: oy_reg  <= cfg_data;
                    nrbh_pkg::REG_DIR_X:    dx_reg  <= cfg_data;
                    nrbh_pkg::REG_DIR_Y:    dy_reg  <= cfg_data;
                    nrbh_pkg::REG_RANGE:    rng_reg <= cfg_data[CW-2:0];
                    default: ;
                endcase
            end
            if (cmd.update && !miss_reg && (!best_v_reg || ts_reg < best_t_reg))
                best_v_reg <= 1'b1;
            if (cmd.emit)
                best_v_reg <= 1'b0;
        end
    end

    assign ddx  = (CW+2)'(box_reg.box_x) - (CW+2)'(ox_reg);
    assign ddy  = (CW+2)'(box_reg.box_y) - (CW+2)'(oy_reg);
    assign absx = ddx_reg[CW+1] ? -ddx_reg : ddx_reg;
    assign absy = ddy_reg[CW+1] ? -ddy_reg : ddy_reg;
    assign dist2 = (2*CW+4)'(unsigned'(absx) * unsigned'(absx))
                 + (2*CW+4)'(unsigned'(absy) * unsigned'(absy));
    assign rng2  = (2*CW+4)'(rng_reg) * (2*CW+4)'(rng_reg);

    always_comb
    begin
        case (cmd.div_sel)
            2'd0:    num_off = ddx_reg;
            2'd1:    num_off = ddx_reg + (CW+2)'(box_reg.box_w);
            2'd2:    num_off = ddy_reg;
            default: num_off = ddy_reg + (CW+2)'(box_reg.box_h);
        endcase
        den = cmd.div_sel[1] ? dy_reg : dx_reg;
        num = {(NW-16)'(num_off), 16'h0000};
    end

    nrbh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start && den != '0),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (quo)
    );

    // Swap near and far per axis, then form entry and exit times and clamp the entry time.
    always_comb
    begin
        nx = (tm_reg[0] > tm_reg[1]) ? tm_reg[1] : tm_reg[0];
        fx = (tm_reg[0] > tm_reg[1]) ? tm_reg[0] : tm_reg[1];
        ny = (tm_reg[2] > tm_reg[3]) ? tm_reg[3] : tm_reg[2];
        fy = (tm_reg[2] > tm_reg[3]) ? tm_reg[2] : tm_reg[3];
        tn = (nx > ny) ? nx : ny;
        tf = (fx < fy) ? fx : fy;
        ts_w = (tn > T_MAX) ? T_MAX : ((tn < T_MIN) ? T_MIN : tn);
    end

    // Contact point: floor of the Q40.16 product is an arithmetic shift.
    assign cx = XW'(ox_reg) + XW'(px_reg >>> 16);
    assign cy = XW'(oy_reg) + XW'(py_reg >>> 16);

    function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi, lo;
        hi = XW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - XW'(1);
        if (v > hi)
            sat_c = hi[CW-1:0];
        else if (v < lo)
            sat_c = lo[CW-1:0];
        else
            sat_c = v[CW-1:0];
    endfunction

    assign cxs = sat_c(cx);
    assign cys = sat_c(cy);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            box_reg <= box;
        if (cmd.filt)
        begin
            ddx_reg  <= ddx;
            ddy_reg  <= ddy;
            skip_reg <= box_reg.is_own || !box_reg.is_target;
            miss_reg <= 1'b0;
        end
        if (cmd.dist_chk)
        begin
            if (absx > (CW+2)'(rng_reg) || absy > (CW+2)'(rng_reg) || dist2 > rng2)
                skip_reg <= 1'b1;
        end
        if (cmd.div_start && den == '0)
        begin
            zd_reg[cmd.div_sel] <= 1'b1;
            if (num_off == '0)
                miss_reg <= 1'b1;
            tm_reg[cmd.div_sel] <= num_off[CW+1] ? -T_INF : T_INF;
        end
        else if (cmd.div_start)
            zd_reg[cmd.div_sel] <= 1'b0;
        if (cmd.div_store && !zd_reg[cmd.div_sel])
            tm_reg[cmd.div_sel] <= EW'(quo);
        if (cmd.eval)
        begin
            if (nx > fy || ny > fx || tf < 0)
                miss_reg <= 1'b1;
            ts_reg <= ts_w[nrbh_pkg::TW-1:0];
        end
        if (cmd.mul)
        begin
            px_reg <= ts_reg * dx_reg;
            py_reg <= ts_reg * dy_reg;
        end
        if (cmd.update && !miss_reg && (!best_v_reg || ts_reg < best_t_reg))
        begin
            best_t_reg  <= ts_reg;
            best_w_reg  <= box_reg.is_wall;
            best_id_reg <= box_reg.is_wall ? '0 : box_reg.box_id;
            best_cx_reg <= cxs;
            best_cy_reg <= cys;
        end
        if (cmd.emit)
        begin
            res_reg.hit_found <= best_v_reg;
            res_reg.hit_id    <= best_v_reg ? best_id_reg : '0;
            res_reg.hit_wall  <= best_v_reg && best_w_reg;
            res_reg.hit_time  <= best_v_reg ? best_t_reg : '0;
            res_reg.contact_x <= best_v_reg ? best_cx_reg : '0;
            res_reg.contact_y <= best_v_reg ? best_cy_reg : '0;
        end
    end

    assign status.skip     = skip_reg;
    assign status.div_done = div_done;
    assign status.div_zero = zd_reg[cmd.div_sel];
    assign status.miss     = miss_reg;
    assign status.last     = box_reg.last_box;
    assign result          = res_reg;
endmodule

// ===== design/nrbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrbh_ctrl: sequencer for one box test
// Steps the datapath through filter, divisions, evaluation and result.
// ----------------------------------------------------------------------------
module nrbh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_busy,
    input  nrbh_pkg::status_t  status,
    output nrbh_pkg::cmd_t     cmd,
    output logic               idle,
    output logic               out_load
);
    nrbh_pkg::state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrbh_pkg::ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            nrbh_pkg::ST_IDLE:
                if (in_fire)
                    state_next = nrbh_pkg::ST_FILT;
            nrbh_pkg::ST_FILT:
                state_next = nrbh_pkg::ST_DIST;
            nrbh_pkg::ST_DIST:
            begin
                sel_next   = '0;
                state_next = nrbh_pkg::ST_DIV_START;
            end
            nrbh_pkg::ST_DIV_START:
                if (status.skip)
                    state_next = nrbh_pkg::ST_EMIT;
                else
                    state_next = nrbh_pkg::ST_DIV_RUN;
            nrbh_pkg::ST_DIV_RUN:
                if (status.div_done || status.div_zero)
                begin
                    if (sel_reg == 2'd3)
                        state_next = nrbh_pkg::ST_EVAL;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = nrbh_pkg::ST_DIV_START;
                    end
                end
            nrbh_pkg::ST_EVAL:
                state_next = nrbh_pkg::ST_MUL;
            nrbh_pkg::ST_MUL:
                state_next = nrbh_pkg::ST_UPDATE;
            nrbh_pkg::ST_UPDATE:
                state_next = nrbh_pkg::ST_EMIT;
            nrbh_pkg::ST_EMIT:
                if (!status.last)
                    state_next = nrbh_pkg::ST_IDLE;
                else if (!out_busy)
                    state_next = nrbh_pkg::ST_IDLE;
            default:
                state_next = nrbh_pkg::ST_IDLE;
        endcase
    end

    // A zero divisor never starts the divider, so store at once.
    always_comb
    begin
        cmd      = '0;
        idle     = 1'b0;
        out_load = 1'b0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            nrbh_pkg::ST_IDLE:
            begin
                idle     = 1'b1;
                cmd.load = in_fire;
            end
            nrbh_pkg::ST_FILT:      cmd.filt = 1'b1;
            nrbh_pkg::ST_DIST:      cmd.dist_chk = 1'b1;
            nrbh_pkg::ST_DIV_START: cmd.div_start = !status.skip;
            nrbh_pkg::ST_DIV_RUN:   cmd.div_store = status.div_done || status.div_zero;
            nrbh_pkg::ST_EVAL:      cmd.eval = 1'b1;
            nrbh_pkg::ST_MUL:       cmd.mul = 1'b1;
            nrbh_pkg::ST_UPDATE:    cmd.update = 1'b1;
            nrbh_pkg::ST_EMIT:
                if (status.last && !out_busy)
                begin
                    cmd.emit = 1'b1;
                    out_load = 1'b1;
                end
            default: ;
        endcase
    end
endmodule

// ===== design/nearest_ray_box_hit.sv =====
// ----------------------------------------------------------------------------
// nearest_ray_box_hit: nearest hit of a 2D ray against a stream of boxes
// Controller and datapath; the ray is held in configuration registers.
// ----------------------------------------------------------------------------
// Usage
//   cfg channel: write the ray (origin, direction, range) while idle, by
//   register index. Each box item on the box channel is filtered (own box,
//   non-target, corner out of range), then slab-tested. The item marked
//   last_box produces one result item on the hit channel and clears the
//   search for the next set.
// Rate
//   One box at a time; a new box is taken only while idle. A filtered box
//   skips the divisions; a tested box runs the one shared bit-serial divider,
//   which computes the four slab times one after another (41 quotient bits
//   each). A division by a zero direction does not start the divider.
// Result
//   The result is loaded into the output register in the emit step of the last box.
// Reset
//   Registers return to origin 0, direction (1.0, 0), full range; no hit kept.
// Stall
//   The result waits in the output register; the next box is still taken,
//   and only a later last box waits for the register to drain.
// ----------------------------------------------------------------------------
module nearest_ray_box_hit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  nrbh_pkg::box_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output nrbh_pkg::hit_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [nrbh_pkg::CW-1:0]           cfg_data
);
    nrbh_pkg::cmd_t    cmd;
    nrbh_pkg::status_t status;
    logic idle, out_load, in_fire, out_valid_reg;

    assign in_ready  = idle;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    nrbh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && !out_ready),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle),
        .out_load (out_load)
    );

    nrbh_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .box      (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .result   (out_data)
    );

    // Hold the result until taken; a new one loads only once drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over a waiting item");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_data) && out_valid))
        else $error("waiting result changed");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("second item accepted while busy");
endmodule

// ===== verif/tb_nearest_ray_box_hit.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_ray_box_hit: self-checking testbench for the nearest ray box hit
// Drives box items and ray register writes, predicts each hit item from the
// ray set-up and the box stream, and compares every hit item field by field.
// ----------------------------------------------------------------------------
module tb_nearest_ray_box_hit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TIME_INF = 64'sd1 <<< 62;
    localparam longint TIME_MAX = 64'sd2147483647;
    localparam longint TIME_MIN = -64'sd2147483648;
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    nrbh_pkg::box_item_t in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    nrbh_pkg::hit_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [nrbh_pkg::CW-1:0] cfg_data = '0;

    // Ray registers as the predictor sees them
    longint ray_ox, ray_oy, ray_dx, ray_dy, ray_range;
    // Running nearest hit of the current box set
    bit     near_valid;
    longint near_time, near_cx, near_cy;
    logic [nrbh_pkg::IDW-1:0] near_id;
    bit     near_wall;

    nrbh_pkg::hit_item_t pending_hits[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    nearest_ray_box_hit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("[nearest_ray_box_hit] ERROR");
        $finish;
    end

    // Slab time for one edge; returns 0 when the box is a miss on this axis
    function automatic bit slab_time(input longint num, input longint d, output longint t);
        if (d == 0)
        begin
            if (num == 0)
                return 1'b0;
            t = (num > 0) ? TIME_INF : -TIME_INF;
            return 1'b1;
        end
        t = (num * 65536) / d;   // SV division truncates toward zero
        return 1'b1;
    endfunction

    function automatic longint floor_q16(input longint v);
        return v >>> 16;         // arithmetic shift rounds toward minus infinity
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Update the nearest hit with one box; emit a hit item on the last box
    task automatic predict_box(input nrbh_pkg::box_item_t b);
        longint dx, dy, nx, fx, ny, fy, tmp, t, tf, ts;
        bit     ok;
        nrbh_pkg::hit_item_t h;
        dx = longint'(b.box_x) - ray_ox;
        dy = longint'(b.box_y) - ray_oy;
        ok = !b.is_own && b.is_target;
        if (ok && (((dx < 0) ? -dx : dx) > ray_range || ((dy < 0) ? -dy : dy) > ray_range))
            ok = 1'b0;
        if (ok && (dx * dx + dy * dy > ray_range * ray_range))
            ok = 1'b0;
        if (ok)
            ok = slab_time(dx, ray_dx, nx) && slab_time(dx + longint'(b.box_w), ray_dx, fx)
                 && slab_time(dy, ray_dy, ny) && slab_time(dy + longint'(b.box_h), ray_dy, fy);
        if (ok)
        begin
            if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
            if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
            if (nx > fy || ny > fx)
                ok = 1'b0;
            t  = (nx > ny) ? nx : ny;
            tf = (fx < fy) ? fx : fy;
            if (tf < 0)
                ok = 1'b0;
        end
        if (ok)
        begin
            ts = clamp(t, TIME_MIN, TIME_MAX);
            if (!near_valid || ts < near_time)
            begin
                near_valid = 1'b1;
                near_time  = ts;
                near_wall  = b.is_wall;
                near_id    = b.is_wall ? '0 : b.box_id;
                near_cx = clamp(ray_ox + floor_q16(ts * ray_dx), COORD_MIN, COORD_MAX);
                near_cy = clamp(ray_oy + floor_q16(ts * ray_dy), COORD_MIN, COORD_MAX);
            end
        end
        if (b.last_box)
        begin
            h = '0;
            if (near_valid)
            begin
                h.hit_found = 1'b1;
                h.hit_id    = near_id;
                h.hit_wall  = near_wall;
                h.hit_time  = near_time[31:0];
                h.contact_x = near_cx[nrbh_pkg::CW-1:0];
                h.contact_y = near_cy[nrbh_pkg::CW-1:0];
            end
            pending_hits.push_back(h);
            near_valid = 1'b0;
        end
    endtask

    // Send one box item, idling first at random
    task automatic send_box(input nrbh_pkg::box_item_t b);
        // Step past the edge that dropped the previous item
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= b;
        predict_box(b);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Write one ray register; only called while the block is idle
    task automatic write_reg(input nrbh_pkg::reg_idx_t idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[nrbh_pkg::CW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            nrbh_pkg::REG_ORIGIN_X: ray_ox = longint'($signed(value[nrbh_pkg::CW-1:0]));
            nrbh_pkg::REG_ORIGIN_Y: ray_oy = longint'($signed(value[nrbh_pkg::CW-1:0]));
            nrbh_pkg::REG_DIR_X:    ray_dx = longint'($signed(value[nrbh_pkg::CW-1:0]));
            nrbh_pkg::REG_DIR_Y:    ray_dy = longint'($signed(value[nrbh_pkg::CW-1:0]));
            default:                ray_range = longint'(value[nrbh_pkg::CW-2:0]);
        endcase
    endtask

    task automatic set_ray(input longint ox, oy, dx, dy, rng);
        // Drain: filtered boxes give no item, so allow the block to settle
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        write_reg(nrbh_pkg::REG_ORIGIN_X, ox);
        write_reg(nrbh_pkg::REG_ORIGIN_Y, oy);
        write_reg(nrbh_pkg::REG_DIR_X, dx);
        write_reg(nrbh_pkg::REG_DIR_Y, dy);
        write_reg(nrbh_pkg::REG_RANGE, rng);
        cfg_valid <= 1'b0;
    endtask

    function automatic nrbh_pkg::box_item_t make_box(input longint x, y, w, h, input int id,
                                                     input bit own, tgt, wall, last);
        nrbh_pkg::box_item_t b;
        b.box_x = x[nrbh_pkg::CW-1:0];
        b.box_y = y[nrbh_pkg::CW-1:0];
        b.box_w = w[nrbh_pkg::CW-2:0];
        b.box_h = h[nrbh_pkg::CW-2:0];
        b.box_id = id[nrbh_pkg::IDW-1:0];
        b.is_own = own;
        b.is_target = tgt;
        b.is_wall = wall;
        b.last_box = last;
        return b;
    endfunction

    // Mostly boxes near the ray, sometimes anywhere in the field range
    function automatic nrbh_pkg::box_item_t random_box(input int span);
        nrbh_pkg::box_item_t b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(nrbh_pkg::box_item_t)-1:0];
        if ($urandom_range(9) < 8)
        begin
            b.box_x = (nrbh_pkg::CW)'(ray_ox + $signed($urandom_range(2 * span) - span));
            b.box_y = (nrbh_pkg::CW)'(ray_oy + $signed($urandom_range(2 * span) - span));
            b.box_w = (nrbh_pkg::CW-1)'($urandom_range(span / 2));
            b.box_h = (nrbh_pkg::CW-1)'($urandom_range(span / 2));
            b.is_own = ($urandom_range(9) == 0);
            b.is_target = ($urandom_range(9) != 0);
        end
        b.last_box = ($urandom_range(4) == 0);
        return b;
    endfunction

    // Directed boxes, first at the reset ray, then at set rays: extremes, flags, zero offsets and edges
    task automatic test_directed();
        send_box(make_box(512, -256, 256, 512, 16'h1234, 0, 1, 0, 1));    // plain hit
        send_box(make_box(512, -256, 256, 512, 7, 1, 1, 0, 1));           // own box
        send_box(make_box(512, -256, 256, 512, 8, 0, 0, 0, 1));           // not a target
        send_box(make_box(512, -256, 256, 512, 9, 0, 1, 1, 1));           // wall
        send_box(make_box(0, 0, 256, 256, 16'hFFFF, 0, 1, 0, 1));         // zero y offset, dir_y 0
        send_box(make_box(-1024, -256, 256, 512, 3, 0, 1, 0, 1));         // behind origin
        send_box(make_box(2048, -256, 256, 512, 4, 0, 1, 0, 0));          // farther
        send_box(make_box(1024, -256, 256, 512, 5, 0, 1, 0, 0));          // nearer
        send_box(make_box(1024, -256, 256, 512, 6, 0, 1, 0, 1));          // tie keeps earlier
        send_box(make_box(-8388608, -8388608, 8388607, 8388607, 1, 0, 1, 0, 1));
        send_box(make_box(8388607, 8388607, 0, 0, 2, 0, 1, 0, 1));
        send_box(make_box(-256, -256, 8388607, 8388607, 10, 0, 1, 0, 1)); // origin inside
        send_box(make_box(0, 0, 0, 0, 0, 0, 1, 1, 1));
        set_ray(0, 0, 1, 0, 4096);                                        // tiny dir
        send_box(make_box(2560, -256, 256, 512, 11, 0, 1, 0, 1));
        send_box(make_box(8192, 0, 256, 256, 12, 0, 1, 0, 1));           // out of range
        set_ray(-8388608, 8388607, -8388608, 8388607, 0);                 // extremes, zero range
        send_box(make_box(-8388608, 8388607, 100, 100, 13, 0, 1, 0, 1));
        send_box(make_box(-8388607, 8388607, 100, 100, 14, 0, 1, 0, 1));
        set_ray(8388607, -8388608, 8388607, -8388608, 8388607);
        send_box(make_box(0, 0, 8388607, 8388607, 15, 0, 1, 0, 1));
        set_ray(0, 0, 0, 0, 8388607);                                     // zero direction
        send_box(make_box(256, 256, 256, 256, 16, 0, 1, 0, 1));
        send_box(make_box(-256, -256, 512, 512, 17, 0, 1, 0, 1));
    endtask

    // Random sets under a mix of ray set-ups
    task automatic test_random(input int count);
        int span;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                span = ($urandom_range(9) == 0) ? 8388607 : 1 << $urandom_range(16, 8);
                set_ray($signed($urandom_range(4096)) - 2048, $signed($urandom_range(4096)) - 2048,
                        ($urandom_range(3) == 0) ? 0 : $signed($urandom_range(1024)) - 512,
                        ($urandom_range(3) == 0) ? 0 : $signed($urandom_range(1024)) - 512,
                        ($urandom_range(4) == 0) ? $urandom_range(8388607)
                                                 : $urandom_range(2 * span));
            end
            send_box(random_box(span));
        end
        send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 1));     // close the open set
    endtask

    // Receiver with random stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each hit item with the oldest expectation
    always @(posedge clk)
    begin
        nrbh_pkg::hit_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected hit item %p", out_data);
                fail_count++;
            end
            else
            begin
                e = pending_hits.pop_front();
                if (out_data.hit_found !== e.hit_found)
                begin
                    $error("hit_found exp %0d got %0d", e.hit_found, out_data.hit_found);
                    fail_count++;
                end
                if (out_data.hit_id !== e.hit_id)
                begin
                    $error("hit_id exp %0d got %0d", e.hit_id, out_data.hit_id);
                    fail_count++;
                end
                if (out_data.hit_wall !== e.hit_wall)
                begin
                    $error("hit_wall exp %0d got %0d", e.hit_wall, out_data.hit_wall);
                    fail_count++;
                end
                if (out_data.hit_time !== e.hit_time)
                begin
                    $error("hit_time exp %0d got %0d", e.hit_time, out_data.hit_time);
                    fail_count++;
                end
                if (out_data.contact_x !== e.contact_x)
                begin
                    $error("contact_x exp %0d got %0d", e.contact_x, out_data.contact_x);
                    fail_count++;
                end
                if (out_data.contact_y !== e.contact_y)
                begin
                    $error("contact_y exp %0d got %0d", e.contact_y, out_data.contact_y);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        ray_ox = 0; ray_oy = 0; ray_dx = 256; ray_dy = 0; ray_range = 8388607;
        near_valid = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 31; recv_idle_pct = 75;
        test_directed();
        test_random(140);
        send_idle_pct = 75; recv_idle_pct = 31;
        test_random(130);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(130);
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("[nearest_ray_box_hit] OK");
        else
            $display("[nearest_ray_box_hit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/nrbh_pkg.sv
design/nrbh_div.sv
design/nrbh_datapath.sv
design/nrbh_ctrl.sv
design/nearest_ray_box_hit.sv
verif/tb_nearest_ray_box_hit.sv
